// File: sv/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants for the sprite RLE decoder
// Decode phases, run kinds, command byte codes and the result record.
// ----------------------------------------------------------------------------
package srd_pkg;

   typedef enum logic [2:0] {
      PH_NORMAL     = 3'd0,
      PH_LITERAL    = 3'd1,
      PH_SHADOW_N   = 3'd2,
      PH_SHADOW_CNT = 3'd3,
      PH_FILL_CNT   = 3'd4,
      PH_FILL_COL   = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   localparam logic [1:0] KIND_COLOR   = 2'd0;
   localparam logic [1:0] KIND_SHADOW  = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_OVERRUN = 2'd3;

   localparam logic [7:0] CMD_EOL      = 8'h00;
   localparam logic [7:0] CMD_END      = 8'h80;
   localparam logic [7:0] CMD_SHADOW   = 8'hC0;
   localparam logic [7:0] CMD_FILL     = 8'hC1;
   localparam logic [7:0] MONO_COLOR   = 8'h01;

   localparam int COORD_W    = 16;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [COORD_W-1:0] run_x;
      logic [COORD_W-1:0] run_y;
      logic [7:0]         run_length;
      logic [1:0]         run_kind;
      logic [7:0]         color_index;
      logic               last;
   } result_type;

endpackage

// File: sv/srd_if.sv
// ----------------------------------------------------------------------------
// srd_if: channel interfaces of the sprite RLE decoder
// Request (code bytes), response (runs) and register write channels.
// ----------------------------------------------------------------------------
interface srd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       final_byte;

   modport source (output valid, output code_byte, output final_byte, input ready);
   modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface srd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] run_x;
   logic [15:0] run_y;
   logic [7:0]  run_length;
   logic [1:0]  run_kind;
   logic [7:0]  color_index;
   logic        last;

   modport source (output valid, output run_x, output run_y, output run_length,
                   output run_kind, output color_index, output last, input ready);
   modport sink   (input valid, input run_x, input run_y, input run_length,
                   input run_kind, input color_index, input last, output ready);
endinterface

interface srd_csr_if;
   logic valid;
   logic ready;
   logic mono_mode;

   modport source (output valid, output mono_mode, input ready);
   modport sink   (input valid, input mono_mode, output ready);
endinterface

// File: sv/sprite_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// sprite_rle_decoder_core: run-length sprite data decoder
// Decodes one code byte per transfer into pixel runs, end and overrun marks.
// ----------------------------------------------------------------------------
// A byte's results are written into the result queue and offered on rsp from there.
// Throughput: one byte per cycle while req is ready; a byte with two results (run
// then overrun) pushes both into the queue. A 4-entry result queue sits between
// the sides and req is ready while at least two entries are free.
// Reset: synchronous, active high; clears phase, counts, position, mode, queue.
// ----------------------------------------------------------------------------
module sprite_rle_decoder_core #(
   parameter int COORD_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   srd_req_if.sink      req_ch,
   srd_rsp_if.source    rsp_ch,
   srd_csr_if.sink      csr_ch
);
   import srd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // decode state
   phase_type             phase_ff, phase_in;
   logic [7:0]            count_left_ff, count_left_in;
   logic [7:0]            pending_ff, pending_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic                  mono_ff;

   // result queue
   result_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      fill_ff, fill_in;

   logic       req_xfer, rsp_xfer;
   logic [7:0] b;
   logic       fin;

   logic                  run_valid;
   logic [7:0]            run_len;
   logic [1:0]            run_kind;
   logic [7:0]            run_col;
   logic                  end_valid;
   logic                  ovr_valid;
   logic [COORD_BITS-1:0] run_pos_x, mark_pos_x, mark_pos_y;
   logic [COORD_BITS-1:0] adv_x;

   result_type res0, res1;
   logic [1:0] push_cnt;

   assign b        = req_ch.code_byte;
   assign fin      = req_ch.final_byte;
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = fill_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign csr_ch.ready = 1'b1;

   // next state and the results one byte causes
   always_comb begin
      phase_in      = phase_ff;
      count_left_in = count_left_ff;
      pending_in    = pending_ff;
      pos_y_in      = pos_y_ff;
      run_valid     = 1'b0;
      run_len       = 8'd0;
      run_kind      = KIND_COLOR;
      run_col       = 8'd0;
      end_valid     = 1'b0;
      ovr_valid     = 1'b0;
      adv_x         = pos_x_ff;
      case (phase_ff)
         PH_NORMAL: begin
            if (b == CMD_EOL) begin
               pos_y_in = pos_y_ff + COORD_BITS'(1);
               adv_x    = '0;
            end else if (b < CMD_END) begin
               if (!mono_ff) begin
                  count_left_in = b;
                  phase_in      = PH_LITERAL;
               end else begin
                  run_valid = 1'b1;
                  run_len   = b;
                  run_col   = MONO_COLOR;
               end
            end else if (b == CMD_END) begin
               end_valid = 1'b1;
               phase_in  = PH_DONE;
            end else if (b < CMD_SHADOW || mono_ff) begin
               // skip (b - 0x80) pixels
               adv_x = pos_x_ff + COORD_BITS'(b[6:0]);
            end else if (b == CMD_SHADOW) begin
               phase_in = PH_SHADOW_N;
            end else if (b == CMD_FILL) begin
               phase_in = PH_FILL_CNT;
            end else begin
               pending_in = {2'b00, b[5:0]};
               phase_in   = PH_FILL_COL;
            end
         end
         PH_LITERAL: begin
            run_valid     = 1'b1;
            run_len       = 8'd1;
            run_col       = b;
            count_left_in = count_left_ff - 8'd1;
            if (count_left_in == 8'd0) phase_in = PH_NORMAL;
         end
         PH_SHADOW_N: begin
            if (b[1:0] != 2'd0) begin
               run_valid = 1'b1;
               run_len   = {6'd0, b[1:0]};
               run_kind  = KIND_SHADOW;
               phase_in  = PH_NORMAL;
            end else begin
               phase_in = PH_SHADOW_CNT;
            end
         end
         PH_SHADOW_CNT: begin
            run_valid = b != 8'd0;
            run_len   = b;
            run_kind  = KIND_SHADOW;
            phase_in  = PH_NORMAL;
         end
         PH_FILL_CNT: begin
            pending_in = b;
            phase_in   = PH_FILL_COL;
         end
         PH_FILL_COL: begin
            run_valid  = pending_ff != 8'd0;
            run_len    = pending_ff;
            run_col    = b;
            pending_in = 8'd0;
            phase_in   = PH_NORMAL;
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_NORMAL;
         end
      endcase

      run_pos_x = pos_x_ff;
      if (run_valid) adv_x = pos_x_ff + COORD_BITS'(run_len);

      // the end or overrun mark carries the position after this byte
      mark_pos_x = adv_x;
      mark_pos_y = pos_y_in;
      pos_x_in   = adv_x;

      if (fin && !end_valid && phase_ff != PH_DONE) ovr_valid = 1'b1;

      // every final byte closes the sprite
      if (fin) begin
         phase_in      = PH_NORMAL;
         count_left_in = 8'd0;
         pending_in    = 8'd0;
         pos_x_in      = '0;
         pos_y_in      = '0;
      end
   end

   // pack results: a run goes first, the closing mark after it
   always_comb begin
      result_type mark;
      mark.run_x       = COORD_W'(mark_pos_x);
      mark.run_y       = COORD_W'(mark_pos_y);
      mark.run_length  = 8'd0;
      mark.run_kind    = end_valid ? KIND_END : KIND_OVERRUN;
      mark.color_index = 8'd0;
      mark.last        = 1'b1;

      res0.run_x       = COORD_W'(run_pos_x);
      res0.run_y       = COORD_W'(pos_y_ff);
      res0.run_length  = run_len;
      res0.run_kind    = run_kind;
      res0.color_index = run_col;
      res0.last        = 1'b0;
      res1             = mark;
      if (!run_valid) res0 = mark;

      push_cnt = 2'(run_valid) + 2'(end_valid || ovr_valid);
      if (!req_xfer) push_cnt = 2'd0;
   end

   assign fill_in = fill_ff + CNT_W'(push_cnt) - CNT_W'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NORMAL;
         count_left_ff <= 8'd0;
         pending_ff    <= 8'd0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         mono_ff       <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
      end else begin
         if (csr_ch.valid) mono_ff <= csr_ch.mono_mode;
         if (req_xfer) begin
            phase_ff      <= phase_in;
            count_left_ff <= count_left_in;
            pending_ff    <= pending_in;
            pos_x_ff      <= pos_x_in;
            pos_y_ff      <= pos_y_in;
         end
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_cnt);
         if (rsp_xfer) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) queue_ff[wr_ptr_ff] <= res0;
      if (push_cnt == 2'd2) queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
   end

   assign rsp_ch.valid       = fill_ff != '0;
   assign rsp_ch.run_x       = queue_ff[rd_ptr_ff].run_x;
   assign rsp_ch.run_y       = queue_ff[rd_ptr_ff].run_y;
   assign rsp_ch.run_length  = queue_ff[rd_ptr_ff].run_length;
   assign rsp_ch.run_kind    = queue_ff[rd_ptr_ff].run_kind;
   assign rsp_ch.color_index = queue_ff[rd_ptr_ff].color_index;
   assign rsp_ch.last        = queue_ff[rd_ptr_ff].last;

   // queue never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // a final byte outside the post-end phase always leaves a result queued
   a_final_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.final_byte && phase_ff != PH_DONE) |=> rsp_ch.valid)
      else $error("final byte left no result");

   // a final byte always returns the decoder to its start state
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.final_byte) |=>
         (phase_ff == PH_NORMAL && pos_x_ff == '0 && pos_y_ff == '0))
      else $error("sprite state not cleared after final byte");

endmodule
